[hw/rtl/horizontal_span_fill_top_defines.svh]
// ----------------------------------------------------------------------------
// Horizontal span fill assertion macros
// Shared assertion wrappers. Each one compiles away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef HORIZONTAL_SPAN_FILL_TOP_DEFINES_SVH
`define HORIZONTAL_SPAN_FILL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define HSF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("horizontal_span_fill assertion failed");
`define HSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("horizontal_span_fill assertion failed");
`else
`define HSF_ASSERT_IMPLY(lbl, ante, cons)
`define HSF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/hsf_pkg.sv]
// ----------------------------------------------------------------------------
// Horizontal span fill package
// Sizes, codes, item types and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package hsf_pkg;

    localparam int STORE_BYTES     = 4096;
    localparam int ADDR_W          = $clog2(STORE_BYTES);
    localparam int X_W             = 12;
    localparam int ROW_BYTES_W     = 10;
    localparam int BASE_W          = X_W + ROW_BYTES_W;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int REG_IDX_W       = PADDR_W - 2;

    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = ROW_BYTES_W'(40);
    localparam logic [REG_IDX_W-1:0]   REG_ROW_BYTES   = REG_IDX_W'(0);

    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_START_RANGE = 3'd1;
    localparam logic [2:0] ST_END_RANGE   = 3'd2;
    localparam logic [2:0] ST_START_AFTER = 3'd3;
    localparam logic [2:0] ST_ROW_RANGE   = 3'd4;
    localparam logic [2:0] ST_ADDR_RANGE  = 3'd5;

    typedef struct packed {
        logic [1:0]     mode;
        logic [X_W-1:0] x_start;
        logic [X_W-1:0] x_end;
        logic [X_W-1:0] row;
        logic [X_W-1:0] address;
        logic [7:0]     write_data;
    } hsf_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_data;
    } hsf_out_t;

    typedef struct packed {
        logic clear_write;
        logic load;
        logic mul;
        logic check;
        logic span_read;
        logic span_write;
        logic byte_read;
        logic byte_write;
        logic result;
    } hsf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic check_ok;
        logic mode_draw;
        logic mode_read;
        logic mode_write;
        logic span_last;
        logic out_full;
    } hsf_stat_t;

endpackage

[hw/rtl/hsf_datapath.sv]
// ----------------------------------------------------------------------------
// Horizontal span fill datapath
// Screen memory, item registers, bounds checks, span masks and result register.
// ----------------------------------------------------------------------------
`include "horizontal_span_fill_top_defines.svh"

module hsf_datapath
    import hsf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hsf_cmd_t               cmd,
    output hsf_stat_t              stat,
    input  hsf_in_t                in_data,
    input  logic                   cfg_we,
    input  logic [ROW_BYTES_W-1:0] cfg_wdata,
    output logic [ROW_BYTES_W-1:0] row_bytes,
    output logic                   out_valid,
    input  logic                   out_stall,
    output hsf_out_t               out_data
);

    logic [7:0]             mem [STORE_BYTES];
    logic [7:0]             mem_q_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    hsf_in_t                item_reg;
    logic [X_W-1:0]         x_cur_reg;
    logic [BASE_W-1:0]      base_reg;
    logic [2:0]             status_reg;
    logic                   out_valid_reg;
    hsf_out_t               out_data_reg;

    logic [2:0]        check_code;
    logic [X_W:0]      row_pixels;
    logic              addr_ok;
    logic [X_W-1:0]    x_byte_end;
    logic              span_last;
    logic [2:0]        last_bit;
    logic [7:0]        span_mask;
    logic [ADDR_W-1:0] span_addr;
    logic [ADDR_W-1:0] byte_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;

    assign row_pixels = {row_bytes_reg, 3'b000};
    assign addr_ok    = 32'(item_reg.address) < STORE_BYTES;

    always_comb
    begin
        check_code = ST_OK;
        priority if (item_reg.mode == MODE_DRAW)
        begin
            priority if ({1'b0, item_reg.x_start} >= row_pixels)
                check_code = ST_START_RANGE;
            else if ({1'b0, item_reg.x_end} >= row_pixels)
                check_code = ST_END_RANGE;
            else if (item_reg.x_start > item_reg.x_end)
                check_code = ST_START_AFTER;
            else if (32'(base_reg) + 32'(row_bytes_reg) > STORE_BYTES)
                check_code = ST_ROW_RANGE;
            else
                check_code = ST_OK;
        end
        else if (item_reg.mode == MODE_READ || item_reg.mode == MODE_WRITE)
        begin
            check_code = addr_ok ? ST_OK : ST_ADDR_RANGE;
        end
        else
        begin
            check_code = ST_OK;
        end
    end

    assign x_byte_end = x_cur_reg | X_W'(7);
    assign span_last  = x_byte_end >= item_reg.x_end;
    assign last_bit   = span_last ? item_reg.x_end[2:0] : 3'd7;
    assign span_mask  = (8'hFF >> x_cur_reg[2:0]) & (8'hFF << (3'd7 - last_bit));
    assign span_addr  = base_reg[ADDR_W-1:0] + ADDR_W'(x_cur_reg[X_W-1:3]);
    assign byte_addr  = ADDR_W'(item_reg.address);

    always_comb
    begin
        priority if (cmd.clear_write)
        begin
            wr_addr = clr_cnt_reg;
            wr_data = 8'h00;
        end
        else if (cmd.span_write)
        begin
            wr_addr = span_addr;
            wr_data = mem_q_reg | span_mask;
        end
        else
        begin
            wr_addr = byte_addr;
            wr_data = item_reg.write_data;
        end
    end

    assign rd_addr = cmd.span_read ? span_addr : byte_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_write || cmd.span_write || cmd.byte_write)
            mem[wr_addr] <= wr_data;
        if (cmd.span_read || cmd.byte_read)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            row_bytes_reg <= ROW_BYTES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_write)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (cfg_we)
                row_bytes_reg <= cfg_wdata;
            if (cmd.result)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !stat.out_full)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= in_data;
            x_cur_reg <= in_data.x_start;
        end
        if (cmd.mul)
            base_reg <= item_reg.row * row_bytes_reg;
        if (cmd.check)
            status_reg <= check_code;
        if (cmd.span_write)
            x_cur_reg <= x_byte_end + X_W'(1);
        if (cmd.result)
        begin
            out_data_reg.status    <= status_reg;
            out_data_reg.read_data <= (item_reg.mode == MODE_READ && status_reg == ST_OK)
                                      ? mem_q_reg : 8'h00;
        end
    end

    assign stat.clear_last = clr_cnt_reg == ADDR_W'(STORE_BYTES - 1);
    assign stat.check_ok   = check_code == ST_OK;
    assign stat.mode_draw  = item_reg.mode == MODE_DRAW;
    assign stat.mode_read  = item_reg.mode == MODE_READ;
    assign stat.mode_write = item_reg.mode == MODE_WRITE;
    assign stat.span_last  = span_last;
    assign stat.out_full   = out_valid_reg && out_stall;

    assign row_bytes = row_bytes_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `HSF_ASSERT_IMPLY(a_span_mask_nonzero, cmd.span_write, span_mask != 8'h00)
    `HSF_ASSERT_NEXT(a_result_valid, cmd.result, out_valid_reg)

endmodule

[hw/rtl/hsf_controller.sv]
// ----------------------------------------------------------------------------
// Horizontal span fill controller
// Sequences the clearing pass, item checks, span read-modify-write and result.
// ----------------------------------------------------------------------------
`include "horizontal_span_fill_top_defines.svh"

module hsf_controller
    import hsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  hsf_stat_t stat,
    output hsf_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_SPAN_RD,
        S_SPAN_WR,
        S_BYTE_RD,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                priority if (stat.check_ok && stat.mode_draw)
                    state_next = S_SPAN_RD;
                else if (stat.check_ok && stat.mode_read)
                    state_next = S_BYTE_RD;
                else if (stat.check_ok && stat.mode_write)
                begin
                    cmd.byte_write = 1'b1;
                    state_next     = S_DONE;
                end
                else
                    state_next = S_DONE;
            end
            S_SPAN_RD:
            begin
                cmd.span_read = 1'b1;
                state_next    = S_SPAN_WR;
            end
            S_SPAN_WR:
            begin
                cmd.span_write = 1'b1;
                state_next     = stat.span_last ? S_DONE : S_SPAN_RD;
            end
            S_BYTE_RD:
            begin
                cmd.byte_read = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_full)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign in_stall = state_reg != S_IDLE;

    `HSF_ASSERT_NEXT(a_accept_to_mul, state_reg == S_IDLE && in_valid, state_reg == S_MUL)
    `HSF_ASSERT_IMPLY(a_one_mem_write, cmd.span_write, !cmd.byte_write && !cmd.clear_write)
    `HSF_ASSERT_NEXT(a_done_holds, state_reg == S_DONE && stat.out_full, state_reg == S_DONE)

endmodule

[hw/rtl/horizontal_span_fill_top.sv]
// ----------------------------------------------------------------------------
// Horizontal span fill top level
// One-bit-per-pixel screen store with span draw and single-byte access.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096-byte screen memory, one byte a cycle,
// and takes no item until the clearing pass ends; configuration writes are
// taken at any time. A draw item reads and then writes the screen memory for
// each byte that its span covers. A read item goes through the multiply,
// check, byte read and result states; a write item writes its byte in the
// check state. One item is worked on at a time, and a new item is taken while
// the previous result still waits in the output register.
module horizontal_span_fill_top
    import hsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hsf_in_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output hsf_out_t           out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    hsf_cmd_t               cmd;
    hsf_stat_t              stat;
    logic                   cfg_we;
    logic                   reg_sel;
    logic [ROW_BYTES_W-1:0] row_bytes;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2] == REG_ROW_BYTES;
    assign cfg_we  = psel && penable && pwrite && reg_sel;
    assign prdata  = reg_sel ? PDATA_W'(row_bytes) : '0;

    hsf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hsf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[ROW_BYTES_W-1:0]),
        .row_bytes (row_bytes),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
